// File: rtl/pcra_pkg.sv
// ----------------------------------------------------------------------------
// pcra_pkg
// Shared types, widths and constants of the port to core round robin
// assigner: field widths, status codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package pcra_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int NUM_CORES_DEF      = 16;
  localparam int PORTS_PER_CORE_DEF = 8;
  localparam int NUM_PORTS_DEF      = 64;

  // Fixed widths of the transaction fields.
  localparam int REQ_TYPE_W = 1;
  localparam int PORT_ID_W  = 6;
  localparam int STATUS_W   = 3;
  localparam int CORE_IDX_W = 4;
  localparam int SLOT_IDX_W = 3;

  // Configuration register file.
  localparam int MASK_W      = 16;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 1;
  localparam logic [REG_IDX_W-1:0] REG_CORE_MASK = 1'b0;

  // Request codes.
  localparam logic REQ_SCHEDULE   = 1'b0;
  localparam logic REQ_DESCHEDULE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_TOTAL_FULL  = 3'd1,
    ST_CORES_FULL  = 3'd2,
    ST_NOT_SCHED   = 3'd3,
    ST_ALREADY     = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_req;
    logic    start_scan;
    logic    scan_next;
    logic    assign_port;
    logic    desc_load;
    logic    shift_wr;
    logic    desc_finish;
    logic    set_err;
    status_e err_code;
    logic    rot_to_start;
    logic    load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_desched;
    logic port_bad;
    logic port_sched;
    logic total_full;
    logic core_ok;
    logic scan_last;
    logic shift_more;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/pcra_req_if.sv
// ----------------------------------------------------------------------------
// pcra_req_if
// Request channel: schedule or deschedule one port.
// ----------------------------------------------------------------------------
interface pcra_req_if;
  logic                                valid;
  logic                                ready;
  logic [pcra_pkg::REQ_TYPE_W-1:0]     req_type;
  logic [pcra_pkg::PORT_ID_W-1:0]      port_id;

  modport source (output valid, output req_type, output port_id, input ready);
  modport sink   (input valid, input req_type, input port_id, output ready);
endinterface

// File: rtl/pcra_rsp_if.sv
// ----------------------------------------------------------------------------
// pcra_rsp_if
// Response channel: outcome of one request.
// ----------------------------------------------------------------------------
interface pcra_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [pcra_pkg::STATUS_W-1:0]       status;
  logic [pcra_pkg::CORE_IDX_W-1:0]     core_index;
  logic [pcra_pkg::SLOT_IDX_W-1:0]     slot_index;
  logic                                core_started;
  logic                                core_stopped;

  modport source (output valid, output status, output core_index, output slot_index,
                  output core_started, output core_stopped, input ready);
  modport sink   (input valid, input status, input core_index, input slot_index,
                  input core_started, input core_stopped, output ready);
endinterface

// File: rtl/port_to_core_round_robin_assigner_top.sv
// ----------------------------------------------------------------------------
// port_to_core_round_robin_assigner_top
// Assigns ports to cores round robin and removes them again, keeping each
// core's port list compact. Configured through an APB-style register port.
//
//   Channel   Dir   Handshake          Payload
//   req_i     in    valid/ready        req_type, port_id
//   rsp_o     out   valid/ready        status, core_index, slot_index,
//                                      core_started, core_stopped
//   APB       in    psel/penable       core_available_mask at address 0
//
// A schedule checks the request, scans the cores one a cycle from the one
// after the pointer and assigns the port, or fails if none qualifies.
// A deschedule looks up the port and moves each later entry down (read,
// then write); a request rejected at the check skips both. Reset clears all counts and
// flags at once. A stalled response waits in the output register while the
// next transaction is processed; only its hand-off waits for the register.
// ----------------------------------------------------------------------------
module port_to_core_round_robin_assigner_top #(
  parameter int NUM_CORES      = pcra_pkg::NUM_CORES_DEF,
  parameter int PORTS_PER_CORE = pcra_pkg::PORTS_PER_CORE_DEF,
  parameter int NUM_PORTS      = pcra_pkg::NUM_PORTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pcra_req_if.sink                        req_i,
  pcra_rsp_if.source                      rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcra_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pcra_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pcra_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [pcra_pkg::MASK_W-1:0]  mask_q;
  logic [pcra_pkg::REG_IDX_W-1:0] reg_idx;
  logic                         cfg_wr;
  pcra_pkg::ctl_cmd_t           cmd;
  pcra_pkg::dp_sts_t            sts;

  assign reg_idx = paddr[pcra_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_wr && (reg_idx == pcra_pkg::REG_CORE_MASK)) begin
      mask_q <= pwdata[pcra_pkg::MASK_W-1:0];
    end
  end

  assign prdata = (reg_idx == pcra_pkg::REG_CORE_MASK) ?
                  pcra_pkg::APB_DATA_W'(mask_q) : '0;

  pcra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcra_dpath #(
    .NUM_CORES      (NUM_CORES),
    .PORTS_PER_CORE (PORTS_PER_CORE),
    .NUM_PORTS      (NUM_PORTS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mask_i         (mask_q),
    .req_type_i     (req_i.req_type),
    .port_id_i      (req_i.port_id),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .status_o       (rsp_o.status),
    .core_index_o   (rsp_o.core_index),
    .slot_index_o   (rsp_o.slot_index),
    .core_started_o (rsp_o.core_started),
    .core_stopped_o (rsp_o.core_stopped)
  );

  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another is in work");

  // A result is never handed over onto a response that is still stalled.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("output register overwritten");

  // A port is only appended when it is new and there is room in total.
  a_assign_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.assign_port |-> (!sts.port_sched && !sts.total_full && sts.core_ok))
    else $error("illegal port assignment");

  // Rejected requests carry no core, slot or flags.
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != pcra_pkg::ST_OK)) |->
      (rsp_o.core_index == '0 && rsp_o.slot_index == '0 &&
       !rsp_o.core_started && !rsp_o.core_stopped))
    else $error("error response with payload");

endmodule

// File: rtl/pcra_ram.sv
// ----------------------------------------------------------------------------
// pcra_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pcra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pcra_ctrl.sv
// ----------------------------------------------------------------------------
// pcra_ctrl
// Sequencer of the assigner: checks a request, steps the core scan or the
// list compaction, and hands the result to the output register.
// ----------------------------------------------------------------------------
module pcra_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcra_pkg::dp_sts_t   sts_i,
  output pcra_pkg::ctl_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CHECK    = 9'b000000010,
    S_SCAN     = 9'b000000100,
    S_ASSIGN   = 9'b000001000,
    S_DREAD    = 9'b000010000,
    S_SHIFT_RD = 9'b000100000,
    S_SHIFT_WR = 9'b001000000,
    S_DFIN     = 9'b010000000,
    S_RESULT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.err_code = pcra_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts_i.req_desched) begin
          if (sts_i.port_bad) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = pcra_pkg::ST_TOTAL_FULL;
            state_d = S_RESULT;
          end else if (sts_i.port_sched) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = pcra_pkg::ST_ALREADY;
            state_d = S_RESULT;
          end else if (sts_i.total_full) begin
            cmd_o.set_err  = 1'b1;
            cmd_o.err_code = pcra_pkg::ST_TOTAL_FULL;
            state_d = S_RESULT;
          end else begin
            cmd_o.start_scan = 1'b1;
            state_d = S_SCAN;
          end
        end else if (sts_i.port_bad || !sts_i.port_sched) begin
          cmd_o.set_err  = 1'b1;
          cmd_o.err_code = pcra_pkg::ST_NOT_SCHED;
          state_d = S_RESULT;
        end else begin
          state_d = S_DREAD;
        end
      end
      S_SCAN: begin
        if (sts_i.core_ok) begin
          state_d = S_ASSIGN;
        end else if (sts_i.scan_last) begin
          // No core qualifies; the pointer still moves past its old place.
          cmd_o.set_err      = 1'b1;
          cmd_o.err_code     = pcra_pkg::ST_CORES_FULL;
          cmd_o.rot_to_start = 1'b1;
          state_d = S_RESULT;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_ASSIGN: begin
        cmd_o.assign_port = 1'b1;
        state_d = S_RESULT;
      end
      S_DREAD: begin
        cmd_o.desc_load = 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        if (sts_i.shift_more) begin
          state_d = S_SHIFT_WR;
        end else begin
          state_d = S_DFIN;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_DFIN: begin
        cmd_o.desc_finish = 1'b1;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/pcra_dpath.sv
// ----------------------------------------------------------------------------
// pcra_dpath
// Datapath of the assigner: per-core counts, scheduled flags, the port list
// and port location RAMs, the rotating pointer and the output register.
// ----------------------------------------------------------------------------
module pcra_dpath #(
  parameter int NUM_CORES      = pcra_pkg::NUM_CORES_DEF,
  parameter int PORTS_PER_CORE = pcra_pkg::PORTS_PER_CORE_DEF,
  parameter int NUM_PORTS      = pcra_pkg::NUM_PORTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcra_pkg::ctl_cmd_t                  cmd_i,
  output pcra_pkg::dp_sts_t                   sts_o,
  input  logic [pcra_pkg::MASK_W-1:0]         mask_i,
  input  logic [pcra_pkg::REQ_TYPE_W-1:0]     req_type_i,
  input  logic [pcra_pkg::PORT_ID_W-1:0]      port_id_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pcra_pkg::STATUS_W-1:0]       status_o,
  output logic [pcra_pkg::CORE_IDX_W-1:0]     core_index_o,
  output logic [pcra_pkg::SLOT_IDX_W-1:0]     slot_index_o,
  output logic                                core_started_o,
  output logic                                core_stopped_o
);

  localparam int CORE_W     = $clog2(NUM_CORES);
  localparam int SLOT_W     = (PORTS_PER_CORE > 1) ? $clog2(PORTS_PER_CORE) : 1;
  localparam int CNT_W      = $clog2(PORTS_PER_CORE + 1);
  localparam int TOT_W      = $clog2(NUM_PORTS + 1);
  localparam int PA_W       = $clog2(NUM_PORTS);
  localparam int LIST_DEPTH = NUM_CORES * PORTS_PER_CORE;
  localparam int LA_W       = $clog2(LIST_DEPTH);
  localparam int INFO_W     = CORE_W + SLOT_W;

  // Request latch.
  logic [pcra_pkg::REQ_TYPE_W-1:0] req_type_q;
  logic [pcra_pkg::PORT_ID_W-1:0]  port_q;

  // Control-plane state.
  logic [NUM_PORTS-1:0] sched_q;
  logic [TOT_W-1:0]     total_q;
  logic [CORE_W-1:0]    rot_q;
  logic [CNT_W-1:0]     count_q [NUM_CORES];

  // Working registers.
  logic [CORE_W-1:0] cur_q;
  logic [CORE_W-1:0] k_q;
  logic [CNT_W-1:0]  idx_q;
  logic [SLOT_W-1:0] slot_q;

  // Result and output register.
  pcra_pkg::status_e res_status_q;
  logic [CORE_W-1:0] res_core_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic              res_started_q;
  logic              res_stopped_q;
  logic              out_valid_q;
  logic [pcra_pkg::STATUS_W-1:0]   out_status_q;
  logic [pcra_pkg::CORE_IDX_W-1:0] out_core_q;
  logic [pcra_pkg::SLOT_IDX_W-1:0] out_slot_q;
  logic                            out_started_q;
  logic                            out_stopped_q;

  logic [PA_W-1:0]      pa;
  logic                 port_bad;
  logic [CORE_W-1:0]    start_core;
  logic [NUM_CORES-1:0] avail_vec;
  logic [CNT_W-1:0]     cnt_cur;
  logic [LA_W-1:0]      list_base;
  logic                 out_free;

  // RAM ports.
  logic                 list_we;
  logic [LA_W-1:0]      list_waddr;
  logic [pcra_pkg::PORT_ID_W-1:0] list_wdata;
  logic [LA_W-1:0]      list_raddr;
  logic [pcra_pkg::PORT_ID_W-1:0] list_rdata;
  logic                 info_we;
  logic [PA_W-1:0]      info_waddr;
  logic [INFO_W-1:0]    info_wdata;
  logic [INFO_W-1:0]    info_rdata;
  logic                 moved_ok;

  assign pa         = PA_W'(port_q);
  assign port_bad   = (int'(port_q) >= NUM_PORTS);
  assign start_core = (rot_q == CORE_W'(NUM_CORES - 1)) ? '0 : rot_q + CORE_W'(1);
  assign cnt_cur    = count_q[cur_q];
  assign list_base  = LA_W'(cur_q) * LA_W'(PORTS_PER_CORE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign moved_ok   = (int'(list_rdata) < NUM_PORTS);

  // Cores beyond the mask width are never available.
  always_comb begin
    for (int c = 0; c < NUM_CORES; c++) begin
      avail_vec[c] = (c < pcra_pkg::MASK_W) ? mask_i[c % pcra_pkg::MASK_W] : 1'b0;
    end
  end

  assign sts_o.req_desched = (req_type_q == pcra_pkg::REQ_DESCHEDULE);
  assign sts_o.port_bad    = port_bad;
  assign sts_o.port_sched  = !port_bad && sched_q[pa];
  assign sts_o.total_full  = (total_q == TOT_W'(NUM_PORTS));
  assign sts_o.core_ok     = avail_vec[cur_q] && (cnt_cur < CNT_W'(PORTS_PER_CORE));
  assign sts_o.scan_last   = (k_q == CORE_W'(NUM_CORES - 1));
  assign sts_o.shift_more  = (idx_q < cnt_cur);
  assign sts_o.out_free    = out_free;

  // Port list: append on assign, move one entry down per shift step.
  assign list_we    = cmd_i.assign_port || cmd_i.shift_wr;
  assign list_waddr = cmd_i.assign_port ? list_base + LA_W'(cnt_cur)
                                        : list_base + LA_W'(idx_q) - LA_W'(1);
  assign list_wdata = cmd_i.assign_port ? port_q : list_rdata;
  assign list_raddr = list_base + LA_W'(idx_q);

  // Port location: set on assign, slot of a moved port on each shift step.
  assign info_we    = cmd_i.assign_port || (cmd_i.shift_wr && moved_ok);
  assign info_waddr = cmd_i.assign_port ? pa : PA_W'(list_rdata);
  assign info_wdata = cmd_i.assign_port ? {cur_q, SLOT_W'(cnt_cur)}
                                        : {cur_q, SLOT_W'(idx_q - CNT_W'(1))};

  pcra_ram #(
    .WIDTH (pcra_pkg::PORT_ID_W),
    .DEPTH (LIST_DEPTH)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  pcra_ram #(
    .WIDTH (INFO_W),
    .DEPTH (NUM_PORTS)
  ) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (info_waddr),
    .wdata_i (info_wdata),
    .raddr_i (pa),
    .rdata_o (info_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_type_q <= req_type_i;
      port_q     <= port_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_q <= '0;
      total_q <= '0;
      rot_q   <= '0;
      for (int c = 0; c < NUM_CORES; c++) begin
        count_q[c] <= '0;
      end
    end else begin
      if (cmd_i.rot_to_start) begin
        rot_q <= start_core;
      end
      if (cmd_i.assign_port) begin
        rot_q          <= cur_q;
        count_q[cur_q] <= cnt_cur + CNT_W'(1);
        sched_q[pa]    <= 1'b1;
        total_q        <= total_q + TOT_W'(1);
      end
      if (cmd_i.desc_finish) begin
        if (cnt_cur != '0) begin
          count_q[cur_q] <= cnt_cur - CNT_W'(1);
        end
        if (total_q != '0) begin
          total_q <= total_q - TOT_W'(1);
        end
        sched_q[pa] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_scan) begin
      cur_q <= start_core;
      k_q   <= '0;
    end else if (cmd_i.scan_next) begin
      cur_q <= (cur_q == CORE_W'(NUM_CORES - 1)) ? '0 : cur_q + CORE_W'(1);
      k_q   <= k_q + CORE_W'(1);
    end else if (cmd_i.desc_load) begin
      cur_q  <= info_rdata[INFO_W-1:SLOT_W];
      slot_q <= info_rdata[SLOT_W-1:0];
      idx_q  <= CNT_W'(info_rdata[SLOT_W-1:0]) + CNT_W'(1);
    end else if (cmd_i.shift_wr) begin
      idx_q <= idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_err) begin
      res_status_q  <= cmd_i.err_code;
      res_core_q    <= '0;
      res_slot_q    <= '0;
      res_started_q <= 1'b0;
      res_stopped_q <= 1'b0;
    end else if (cmd_i.assign_port) begin
      res_status_q  <= pcra_pkg::ST_OK;
      res_core_q    <= cur_q;
      res_slot_q    <= SLOT_W'(cnt_cur);
      res_started_q <= (cnt_cur == '0);
      res_stopped_q <= 1'b0;
    end else if (cmd_i.desc_finish) begin
      res_status_q  <= pcra_pkg::ST_OK;
      res_core_q    <= cur_q;
      res_slot_q    <= slot_q;
      res_started_q <= 1'b0;
      res_stopped_q <= (cnt_cur <= CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q  <= res_status_q;
      out_core_q    <= pcra_pkg::CORE_IDX_W'(res_core_q);
      out_slot_q    <= pcra_pkg::SLOT_IDX_W'(res_slot_q);
      out_started_q <= res_started_q;
      out_stopped_q <= res_stopped_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign core_index_o   = out_core_q;
  assign slot_index_o   = out_slot_q;
  assign core_started_o = out_started_q;
  assign core_stopped_o = out_stopped_q;

endmodule
